// ===== hdl/tpag_pkg.sv =====
package tpag_pkg;

  // Fixed field widths of the ports.
  localparam int OFF_W       = 48;  // destination and source offsets
  localparam int CFG_W       = 12;  // widest configuration register
  localparam int CFG_IDX_W   = 3;   // register index
  localparam int DC_W        = 3;   // dim_count register
  localparam int PERM_W      = 8;   // perm_map register
  localparam int PERM_BITS   = 2;   // one permutation field
  localparam int PERM_FIELDS = PERM_W / PERM_BITS;
  localparam int SIZE_REGS   = 4;   // src_size_0..src_size_3
  localparam int CNT_W       = 64;  // element count, wraps like the spec

  // Offset divider: quotient bits retired per pipeline stage.
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = OFF_W / DIV_BPS;

  // Reset values.
  localparam logic [DC_W-1:0]   DIM_COUNT_RST = DC_W'(1);
  localparam logic [PERM_W-1:0] PERM_MAP_RST  = PERM_W'(228);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT,
    REG_SRC_SIZE_0,
    REG_SRC_SIZE_1,
    REG_SRC_SIZE_2,
    REG_SRC_SIZE_3,
    REG_PERM_MAP
  } cfg_reg_t;

endpackage

// ===== hdl/tensor_permute_address_generator_unit.sv =====
// Permuted-tensor address generator.
//
// Input channel: an item (dst_offset) is taken at every rising edge with
// start high and busy low. busy is held low, so an item may enter every
// cycle, back to back, for a sustained rate of one item per clock.
// Result channel: done strobes for exactly one cycle with rd_offset and
// in_range; the receiver cannot stall, so nothing waits inside the block.
// in_range is 0 when dst_offset is not below the product of the used source
// sizes, and rd_offset is then 0.
// Configuration: cfg_we/cfg_index/cfg_data, one register per edge (index 0
// dim_count, 1..4 sizes, 5 perm). The user must write them only while no
// item is in flight; the block itself does not enforce this.
// Pipeline: first the offset divider, in which each inner destination
// dimension takes one 48-bit restoring division by its 12-bit size,
// 4 quotient bits per stage. After that come one scatter stage through
// the permutation, one multiply-add stage per dimension for the row-major
// recombine (the element count is formed alongside), and the output
// register.
// Reset: synchronous, clears all valid bits and the strobe, and loads
// dim_count 1, all sizes 1 and the identity permutation.
module tensor_permute_address_generator_unit
  import tpag_pkg::*;
#(
  parameter int MAX_DIMS = 4,
  parameter int DIM_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OFF_W-1:0]     dst_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [OFF_W-1:0]     rd_offset,
  output logic                 in_range
);

  localparam int N_W     = $clog2(MAX_DIMS + 1);
  localparam int NC_W    = (N_W > DC_W) ? N_W : DC_W;
  localparam int CMP_W   = (NC_W > PERM_BITS) ? NC_W : PERM_BITS;
  localparam int DIVS    = (MAX_DIMS - 1) * DIV_STAGES;
  localparam int LATENCY = DIVS + MAX_DIMS + 2;

  // Divider stage: off is kept for the range check, quo shifts the dividend
  // out and the quotient in, rem is the running remainder.
  typedef struct packed {
    logic                               valid;
    logic [OFF_W-1:0]                   off;
    logic [OFF_W-1:0]                   quo;
    logic [DIM_BITS-1:0]                rem;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]  didx;
  } div_t;

  // Recombine stage.
  typedef struct packed {
    logic                               valid;
    logic [OFF_W-1:0]                   off;
    logic [OFF_W-1:0]                   acc;
    logic [CNT_W-1:0]                   cnt;
    logic [MAX_DIMS-1:0][OFF_W-1:0]     sidx;
  } hz_t;

  // ---------------------------------------------------------------- config
  logic [DC_W-1:0]     dim_count;
  logic [PERM_W-1:0]   perm_map;
  logic [DIM_BITS-1:0] src_size [MAX_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= DIM_COUNT_RST;
      perm_map  <= PERM_MAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dim_count <= cfg_data[DC_W-1:0];
        REG_PERM_MAP:  perm_map  <= cfg_data[PERM_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_size
    if (i < SIZE_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          src_size[i] <= DIM_BITS'(1);
        end else if (cfg_we &&
                     cfg_index == CFG_IDX_W'(REG_SRC_SIZE_0) + CFG_IDX_W'(i)) begin
          src_size[i] <= DIM_BITS'(cfg_data);
        end
      end
    end else begin : g_fixed
      assign src_size[i] = DIM_BITS'(1);
    end
  end

  // Dimensions in use: zero counts as one, clamp at MAX_DIMS.
  logic [N_W-1:0] n_used;
  always_comb begin
    if (dim_count == '0) begin
      n_used = N_W'(1);
    end else if (NC_W'(dim_count) > NC_W'(MAX_DIMS)) begin
      n_used = N_W'(MAX_DIMS);
    end else begin
      n_used = N_W'(dim_count);
    end
  end

  // Per dimension: permutation field, whether it is used and names a used
  // source dim, the effective source size and the destination size.
  logic [PERM_BITS-1:0] pf     [MAX_DIMS];
  logic                 pf_ok  [MAX_DIMS];
  logic [DIM_BITS-1:0]  esize  [MAX_DIMS];
  logic [DIM_BITS-1:0]  dsz    [MAX_DIMS];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    if (k < PERM_FIELDS) begin : g_pf
      assign pf[k] = perm_map[PERM_BITS*k +: PERM_BITS];
    end else begin : g_pf0
      assign pf[k] = '0;
    end

    assign pf_ok[k] = (N_W'(k) < n_used) && (CMP_W'(pf[k]) < CMP_W'(n_used));
    assign esize[k] = (N_W'(k) < n_used) ? src_size[k] : DIM_BITS'(1);

    always_comb begin
      dsz[k] = DIM_BITS'(1);
      for (int q = 0; q < MAX_DIMS; q++) begin
        if (pf_ok[k] && CMP_W'(pf[k]) == CMP_W'(q)) dsz[k] = src_size[q];
      end
    end
  end

  // --------------------------------------------------------------- divider
  // Inner dimensions first: didx[k] = rest mod dsz[k], rest = rest / dsz[k].
  // What is left after dimension 1 is the outermost index, unreduced.
  div_t dv [DIVS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid <= start && !busy;
    end
    dv[0].off  <= dst_offset;
    dv[0].quo  <= dst_offset;
    dv[0].rem  <= '0;
    dv[0].didx <= '0;
  end

  for (genvar i = 0; i < DIVS; i++) begin : g_div
    localparam int J    = i / DIV_STAGES;
    localparam int K    = MAX_DIMS - 1 - J;
    localparam bit LAST = (i % DIV_STAGES) == (DIV_STAGES - 1);

    logic [OFF_W-1:0]    q;
    logic [DIM_BITS-1:0] r;
    logic [DIM_BITS:0]   t;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] didx_next;

    always_comb begin
      q = dv[i].quo;
      r = dv[i].rem;
      t = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        t = {r, q[OFF_W-1]};
        q = {q[OFF_W-2:0], 1'b0};
        if (t >= {1'b0, dsz[K]}) begin
          t    = t - {1'b0, dsz[K]};
          q[0] = 1'b1;
        end
        r = t[DIM_BITS-1:0];
      end
    end

    // Last stage of a dimension drops the remainder into its index slot.
    always_comb begin
      didx_next = dv[i].didx;
      if (LAST) didx_next[K] = r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1].valid <= 1'b0;
      end else begin
        dv[i+1].valid <= dv[i].valid;
      end
      dv[i+1].off  <= dv[i].off;
      dv[i+1].quo  <= q;
      dv[i+1].didx <= didx_next;
      if (LAST) begin
        dv[i+1].rem <= '0;
      end else begin
        dv[i+1].rem <= r;
      end
    end
  end

  // --------------------------------------------------------------- scatter
  // sidx[p] takes the last destination index whose field names p.
  hz_t                hz [MAX_DIMS+1];
  logic [OFF_W-1:0]   dfull    [MAX_DIMS];
  logic [MAX_DIMS-1:0][OFF_W-1:0] sidx_next;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dfull
    if (k == 0) begin : g_outer
      assign dfull[k] = dv[DIVS].quo;
    end else begin : g_inner
      assign dfull[k] = OFF_W'(dv[DIVS].didx[k]);
    end
  end

  always_comb begin
    for (int p = 0; p < MAX_DIMS; p++) begin
      sidx_next[p] = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        if (pf_ok[k] && CMP_W'(pf[k]) == CMP_W'(p)) sidx_next[p] = dfull[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hz[0].valid <= 1'b0;
    end else begin
      hz[0].valid <= dv[DIVS].valid;
    end
    hz[0].off  <= dv[DIVS].off;
    hz[0].acc  <= '0;
    hz[0].cnt  <= CNT_W'(1);
    hz[0].sidx <= sidx_next;
  end

  // ------------------------------------------------------------- recombine
  // Horner over the source sizes; the element count rides along.
  for (genvar h = 0; h < MAX_DIMS; h++) begin : g_horner
    logic [OFF_W+DIM_BITS-1:0] acc_prod;
    logic [CNT_W+DIM_BITS-1:0] cnt_prod;

    assign acc_prod = hz[h].acc * esize[h];
    assign cnt_prod = hz[h].cnt * esize[h];

    always_ff @(posedge clk) begin
      if (rst) begin
        hz[h+1].valid <= 1'b0;
      end else begin
        hz[h+1].valid <= hz[h].valid;
      end
      hz[h+1].off  <= hz[h].off;
      hz[h+1].acc  <= acc_prod[OFF_W-1:0] + hz[h].sidx[h];
      hz[h+1].cnt  <= cnt_prod[CNT_W-1:0];
      hz[h+1].sidx <= hz[h].sidx;
    end
  end

  // ---------------------------------------------------------------- output
  logic hit;
  assign hit = CNT_W'(hz[MAX_DIMS].off) < hz[MAX_DIMS].cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hz[MAX_DIMS].valid;
    end
    in_range  <= hit;
    rd_offset <= hit ? hz[MAX_DIMS].acc : '0;
  end

  // ------------------------------------------------------------ assertions
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY + 1) done)
    else $error("item did not come out after the pipeline latency");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (hz[MAX_DIMS].valid && hz[MAX_DIMS].cnt == '0) |=> (done && !in_range))
    else $error("zero element count reported in range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (rd_offset == '0))
    else $error("out of range item with nonzero source offset");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("strobe right after reset");

endmodule
